// ===== src/rsq_pkg.sv =====
// ----------------------------------------------------------------------------
// rsq_pkg: shared types and constants for the risk scored priority queue
// command and status codes, key arithmetic and the cell control bundle
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int KEY_W = 13;
    localparam int ID_W  = 16;
    localparam int BMI_W = 12;
    localparam int A1C_W = 8;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;
    localparam int OCC_W = 6;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // a1c thresholds in tenths of a percent
    localparam logic [A1C_W-1:0] A1C_PREDIABETES  = 8'd57;
    localparam logic [A1C_W-1:0] A1C_DIABETES_MAX = 8'd65;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [ID_W-1:0]  id_t;

    // per-cycle shift control broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

    // risk 0, 1 or 2 times bmi, kept to the key width
    function automatic key_t risk_key(input logic [BMI_W-1:0] bmi,
                                      input logic [A1C_W-1:0] a1c);
        key_t k;
        if (a1c < A1C_PREDIABETES)
            k = '0;
        else if (a1c <= A1C_DIABETES_MAX)
            k = {1'b0, bmi};
        else
            k = {bmi, 1'b0};
        return k;
    endfunction

endpackage

// ===== src/rsq_cell.sv =====
// ----------------------------------------------------------------------------
// rsq_cell: one slot of the sorted queue chain
// holds a key and id, compares against the incoming key, shifts with neighbors
// ----------------------------------------------------------------------------
module rsq_cell
    import rsq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  key_t       new_key,
    input  id_t        new_id,
    input  logic       occupied,
    input  logic       prev_ge,
    input  key_t       prev_key,
    input  id_t        prev_id,
    input  key_t       next_key,
    input  id_t        next_id,
    output key_t       key,
    output id_t        id,
    output logic       ge
);

    key_t key_reg, key_next;
    id_t  id_reg,  id_next;

    // this slot stays put on insert when it holds a key at least as large
    assign ge = occupied && (key_reg >= new_key);

    always_comb
    begin
        key_next = key_reg;
        id_next  = id_reg;
        if (ctrl.ins && !ge)
        begin
            if (prev_ge)
            begin
                key_next = new_key;
                id_next  = new_id;
            end
            else
            begin
                key_next = prev_key;
                id_next  = prev_id;
            end
        end
        else if (ctrl.pop)
        begin
            key_next = next_key;
            id_next  = next_id;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign key = key_reg;
    assign id  = id_reg;

endmodule

// ===== src/risk_scored_priority_queue.sv =====
// ----------------------------------------------------------------------------
// risk_scored_priority_queue: bounded queue sorted by risk key
// a row of shifting cells keeps entries in descending key order
// ----------------------------------------------------------------------------
// One command is taken per clock: start with busy low is a beat, and busy is
// always low, so commands may follow back to back. The result beat appears on
// done in the cycle after the command beat, every time; the receiver cannot
// stall it and must take it in that cycle. Each command finishes without a
// stall because every cell compares its key to the new key at once and
// then shifts in step with its neighbors. Enqueue computes key = risk * bmi,
// risk being 0, 1 or 2 from the a1c band, and places the entry behind all
// entries with a key greater or equal, so ties leave in arrival order.
// Dequeue pops the head, flush empties the queue. Slot contents are not
// cleared by reset; only the count and done are. Cells past it are never read.
// ----------------------------------------------------------------------------
module risk_scored_priority_queue
    import rsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [ID_W-1:0]   patient_id,
    input  logic [BMI_W-1:0]  bmi_q4,
    input  logic [A1C_W-1:0]  a1c_tenths,
    output logic              done,
    output logic [ST_W-1:0]   status,
    output logic [ID_W-1:0]   served_id,
    output logic [KEY_W-1:0]  served_key,
    output logic [OCC_W-1:0]  occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // fill count, the only control state besides the result strobe
    logic [CNT_W-1:0] count_reg, count_next;

    logic             done_reg;
    logic [ST_W-1:0]  status_reg,  status_next;
    id_t              sid_reg,     sid_next;
    key_t             skey_reg,    skey_next;

    logic       accept;
    logic       full;
    logic       empty;
    key_t       new_key;
    cell_ctrl_t ctrl;

    // per-cell taps of the chain
    key_t cell_key [QUEUE_DEPTH];
    id_t  cell_id  [QUEUE_DEPTH];
    logic cell_ge  [QUEUE_DEPTH];

    // never stalls: every command completes without waiting
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == DEPTH_CNT);
    assign empty  = (count_reg == '0);

    assign new_key = risk_key(bmi_q4, a1c_tenths);

    // shift control seen by every cell; a full queue drops the new entry
    assign ctrl.ins = accept && (command == CMD_ENQUEUE) && !full;
    assign ctrl.pop = accept && (command == CMD_DEQUEUE) && !empty;

    // ------------------------------------------------------------------
    // cell row, head at index 0
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic occ;
            logic prv_ge;
            key_t prv_key, nxt_key;
            id_t  prv_id,  nxt_id;

            assign occ = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                // head always takes the new entry when it does not hold
                assign prv_ge  = 1'b1;
                assign prv_key = new_key;
                assign prv_id  = patient_id;
            end
            else
            begin : g_body
                assign prv_ge  = cell_ge[gi-1];
                assign prv_key = cell_key[gi-1];
                assign prv_id  = cell_id[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                // tail refills from itself on pop; it is past the count then
                assign nxt_key = cell_key[gi];
                assign nxt_id  = cell_id[gi];
            end
            else
            begin : g_inner
                assign nxt_key = cell_key[gi+1];
                assign nxt_id  = cell_id[gi+1];
            end

            rsq_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .new_key  (new_key),
                .new_id   (patient_id),
                .occupied (occ),
                .prev_ge  (prv_ge),
                .prev_key (prv_key),
                .prev_id  (prv_id),
                .next_key (nxt_key),
                .next_id  (nxt_id),
                .key      (cell_key[gi]),
                .id       (cell_id[gi]),
                .ge       (cell_ge[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // count and result beat
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        sid_next    = '0;
        skey_next   = '0;
        case (command)
            CMD_ENQUEUE:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            CMD_DEQUEUE:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    count_next = count_reg - 1'b1;
                    sid_next   = cell_id[0];
                    skey_next  = cell_key[0];
                end
            end
            CMD_FLUSH:
            begin
                count_next = '0;
            end
            default:
            begin
                // unused code: no change, plain done
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    // result payload, loaded with each command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            sid_reg    <= sid_next;
            skey_reg   <= skey_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign served_id  = sid_reg;
    assign served_key = skey_reg;
    assign occupancy  = OCC_W'(count_reg);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count beyond queue depth");

    a_done_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("command beat without result beat");

    a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> full)
        else $error("full reported while queue has room");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> empty)
        else $error("empty reported while queue holds entries");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_key[0] >= cell_key[1]))
        else $error("head key below second key");

endmodule
